/* hdl/ja3p_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ja3p_pkg
// Types, widths and the arctangent table of the joint angle block.
// ---------------------------------------------------------------------------
package ja3p_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int DIFF_W          = COORD_WIDTH + 1;   // joint difference
  localparam int PROD_W          = 2 * DIFF_W;        // one partial product
  localparam int SUM_W           = PROD_W + 1;        // dot / cross, exact
  localparam int CW              = SUM_W + 2;         // CORDIC x/y, room for gain
  localparam int ZW              = 33;                // angle acc, 1/100 deg * 2^16
  localparam int ZFRAC           = 16;
  localparam int ANGLE_W         = 17;
  localparam int ASUM_W          = ANGLE_W + 2;       // sign + offset headroom
  localparam int OFFS_W          = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int ATAN_LEN        = 24;
  localparam int CORDIC_ITER_DEF = 16;
  localparam int ANGLE_LIMIT     = 36000;

  localparam logic signed [ZW-1:0] HALF_TURN  = 33'sd1179648000;  // 18000 * 2^16
  localparam logic signed [ZW-1:0] ROUND_HALF = 33'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REVERSE_SIGN = 1'b0,
    REG_ANGLE_OFFSET = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                          tracked;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] middle_x;
    logic signed [COORD_WIDTH-1:0] middle_y;
    logic signed [COORD_WIDTH-1:0] middle_z;
    logic signed [COORD_WIDTH-1:0] last_x;
    logic signed [COORD_WIDTH-1:0] last_y;
    logic signed [COORD_WIDTH-1:0] last_z;
  } in_word_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      valid_res;
    logic                      degenerate;
  } out_word_t;

  typedef struct packed {
    logic vld;        // word present in this stage
    logic trk;        // body tracked
    logic degen;      // a zero-length difference vector
    logic both_zero;  // dot and cross both zero
  } ctl_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } cstate_t;

  // round(atan(2^-i) * 180/pi * 100 * 2^16)
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 33'sd294912000;
      5'd1:    v = 33'sd174096719;
      5'd2:    v = 33'sd91987925;
      5'd3:    v = 33'sd46694507;
      5'd4:    v = 33'sd23437865;
      5'd5:    v = 33'sd11730358;
      5'd6:    v = 33'sd5866610;
      5'd7:    v = 33'sd2933485;
      5'd8:    v = 33'sd1466764;
      5'd9:    v = 33'sd733385;
      5'd10:   v = 33'sd366693;
      5'd11:   v = 33'sd183346;
      5'd12:   v = 33'sd91673;
      5'd13:   v = 33'sd45837;
      5'd14:   v = 33'sd22918;
      5'd15:   v = 33'sd11459;
      5'd16:   v = 33'sd5730;
      5'd17:   v = 33'sd2865;
      5'd18:   v = 33'sd1432;
      5'd19:   v = 33'sd716;
      5'd20:   v = 33'sd358;
      5'd21:   v = 33'sd179;
      5'd22:   v = 33'sd90;
      5'd23:   v = 33'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/ja3p_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ja3p_front
// Difference vectors, dot and cross products, and the half-turn pre-rotation
// that feeds the CORDIC cell row. Four register stages.
// ---------------------------------------------------------------------------
module ja3p_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  ja3p_pkg::in_word_t  in_word,
  output ja3p_pkg::cstate_t   st_o
);
  import ja3p_pkg::*;

  // stage 0: differences
  logic                     s0_vld_r, s0_trk_r;
  logic signed [DIFF_W-1:0] a_r [3];
  logic signed [DIFF_W-1:0] b_r [3];

  // stage 1: products
  logic                     s1_vld_r, s1_trk_r, s1_degen_r;
  logic signed [PROD_W-1:0] p_r [5];
  logic                     zero_a, zero_b;

  // stage 2: dot and cross
  logic                     s2_vld_r, s2_trk_r, s2_degen_r;
  logic signed [SUM_W-1:0]  dot_r, cross_r;

  // stage 3: pre-rotated CORDIC start
  cstate_t                  st_r, st_nxt;

  always_ff @(posedge clk) begin
    a_r[0] <= DIFF_W'(in_word.first_x)  - DIFF_W'(in_word.middle_x);
    a_r[1] <= DIFF_W'(in_word.first_y)  - DIFF_W'(in_word.middle_y);
    a_r[2] <= DIFF_W'(in_word.first_z)  - DIFF_W'(in_word.middle_z);
    b_r[0] <= DIFF_W'(in_word.middle_x) - DIFF_W'(in_word.last_x);
    b_r[1] <= DIFF_W'(in_word.middle_y) - DIFF_W'(in_word.last_y);
    b_r[2] <= DIFF_W'(in_word.middle_z) - DIFF_W'(in_word.last_z);
    s0_trk_r <= in_word.tracked;
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  assign zero_a = (a_r[0] == '0) && (a_r[1] == '0) && (a_r[2] == '0);
  assign zero_b = (b_r[0] == '0) && (b_r[1] == '0) && (b_r[2] == '0);

  always_ff @(posedge clk) begin
    p_r[0]     <= PROD_W'(a_r[0] * b_r[0]);
    p_r[1]     <= PROD_W'(a_r[1] * b_r[1]);
    p_r[2]     <= PROD_W'(a_r[2] * b_r[2]);
    p_r[3]     <= PROD_W'(a_r[0] * b_r[1]);
    p_r[4]     <= PROD_W'(a_r[1] * b_r[0]);
    s1_trk_r   <= s0_trk_r;
    s1_degen_r <= zero_a | zero_b;
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dot_r      <= SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + SUM_W'(p_r[2]);
    cross_r    <= SUM_W'(p_r[3]) - SUM_W'(p_r[4]);
    s2_trk_r   <= s1_trk_r;
    s2_degen_r <= s1_degen_r;
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // negative dot: turn by 180 deg so x starts non-negative
  always_comb begin
    st_nxt.ctl.vld       = s2_vld_r;
    st_nxt.ctl.trk       = s2_trk_r;
    st_nxt.ctl.degen     = s2_degen_r;
    st_nxt.ctl.both_zero = (dot_r == '0) && (cross_r == '0);
    if (dot_r < 0) begin
      st_nxt.x = -CW'(dot_r);
      st_nxt.y = -CW'(cross_r);
      st_nxt.z = (cross_r >= 0) ? HALF_TURN : -HALF_TURN;
    end else begin
      st_nxt.x = CW'(dot_r);
      st_nxt.y = CW'(cross_r);
      st_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

/* hdl/ja3p_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ja3p_cell
// One vectoring CORDIC micro-rotation, registered; IDX sets shift and angle.
// ---------------------------------------------------------------------------
module ja3p_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ja3p_pkg::cstate_t st_i,
  output ja3p_pkg::cstate_t st_o
);
  import ja3p_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_entry(5'(IDX));

  logic signed [CW-1:0] xs, ys;
  cstate_t              st_r, st_nxt;

  assign xs = st_i.x >>> IDX;
  assign ys = st_i.y >>> IDX;

  always_comb begin
    st_nxt = st_i;
    if (st_i.y > 0) begin
      st_nxt.x = st_i.x + ys;
      st_nxt.y = st_i.y - xs;
      st_nxt.z = st_i.z + ANG;
    end else begin
      st_nxt.x = st_i.x - ys;
      st_nxt.y = st_i.y + xs;
      st_nxt.z = st_i.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

/* hdl/joint_angle_from_three_points.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_angle_from_three_points
// Joint angle, in 1/100 degree, from three 3D joint positions.
// ---------------------------------------------------------------------------
// Path: each accepted word passes four front stages, one CORDIC cell per
//   iteration (at most ATAN_LEN cells) and one output stage; out_strobe then
//   marks its result word.
// Throughput: one word per cycle; busy stays low, every stage is a register.
// Reset: synchronous rst_n drops all in-flight words and clears both config regs.
// ---------------------------------------------------------------------------
module joint_angle_from_three_points #(
  parameter int CORDIC_ITERATIONS = ja3p_pkg::CORDIC_ITER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ja3p_pkg::in_word_t                in_data,
  output logic                              out_strobe,
  output ja3p_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [ja3p_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ja3p_pkg::OFFS_W-1:0]       cfg_wdata
);
  import ja3p_pkg::*;

  localparam int NCELL = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
  localparam int LATENCY = NCELL + 5;

  logic                      rev_r;
  logic signed [OFFS_W-1:0]  offset_r;
  logic                      accept;
  cstate_t                   chain [NCELL+1];
  cstate_t                   last;

  logic signed [ZW-1:0]      z_rnd;
  logic signed [ANGLE_W-1:0] ang_c;
  logic signed [ASUM_W-1:0]  ang_s, ang_sum;
  out_word_t                 out_r, out_nxt;
  logic                      strobe_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r    <= 1'b0;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_REVERSE_SIGN: rev_r    <= cfg_wdata[0];
        REG_ANGLE_OFFSET: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ja3p_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_data),
    .st_o    (chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ja3p_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .st_i  (chain[i]),
      .st_o  (chain[i+1])
    );
  end

  assign last = chain[NCELL];

  // round z to 1/100 deg (zero if dot and cross are both zero), apply sign and offset, saturate
  always_comb begin
    z_rnd = last.z + ROUND_HALF;
    ang_c = last.ctl.both_zero ? '0 : z_rnd[ZW-1:ZFRAC];
    ang_s = ASUM_W'(ang_c);
    if (rev_r) begin
      ang_s = -ang_s;
    end
    ang_sum = ang_s + ASUM_W'(offset_r);
    if (ang_sum > ASUM_W'(ANGLE_LIMIT)) begin
      ang_sum = ASUM_W'(ANGLE_LIMIT);
    end else if (ang_sum < -ASUM_W'(ANGLE_LIMIT)) begin
      ang_sum = -ASUM_W'(ANGLE_LIMIT);
    end
  end

  always_comb begin
    out_nxt.angle      = ang_sum[ANGLE_W-1:0];
    out_nxt.valid_res  = 1'b1;
    out_nxt.degenerate = 1'b0;
    if (!last.ctl.trk) begin
      out_nxt.angle     = '0;
      out_nxt.valid_res = 1'b0;
    end else if (last.ctl.degen) begin
      out_nxt.angle      = '0;
      out_nxt.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= last.ctl.vld;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

/* hdl/ja3p_chk.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ja3p_chk
// Port-level checks of the joint angle block, bound to the top level.
// ---------------------------------------------------------------------------
module ja3p_chk #(
  parameter int LAT = 21
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ja3p_pkg::in_word_t  in_data,
  input logic                out_strobe,
  input ja3p_pkg::out_word_t out_data
);
  import ja3p_pkg::*;

  localparam int CNT_W = $clog2(LAT + 1);

  // cycles since reset, so the pipeline holds only post-reset words
  logic [CNT_W-1:0] since_r;
  logic             settled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r <= '0;
    end else if (since_r != CNT_W'(LAT)) begin
      since_r <= since_r + 1'b1;
    end
  end

  assign settled = (since_r == CNT_W'(LAT));

  // every accepted word yields exactly one word, a fixed time later
  a_one_per_word: assert property (@(posedge clk) disable iff (!rst_n)
    settled |-> (out_strobe == $past(start && !busy && rst_n, LAT)))
    else $error("result word count/timing mismatch");

  a_valid_follows_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (settled && out_strobe) |-> (out_data.valid_res == $past(in_data.tracked, LAT)))
    else $error("valid_res does not follow tracked");

  a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.valid_res) |-> (out_data.angle == '0 && !out_data.degenerate))
    else $error("untracked word not cleared");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.degenerate) |-> (out_data.angle == '0 && out_data.valid_res))
    else $error("degenerate word has nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.angle <= ANGLE_W'(ANGLE_LIMIT) &&
                    out_data.angle >= -ANGLE_W'(ANGLE_LIMIT)))
    else $error("angle outside saturation range");

endmodule

bind joint_angle_from_three_points ja3p_chk #(.LAT(LATENCY)) u_ja3p_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
